// ===== hdl/kgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgr_pkg
// Shared widths, register indexes, state and status types for the k-group
// reverser.
// ----------------------------------------------------------------------------
package kgr_pkg;

    localparam int VAL_W      = 32;   // element width
    localparam int GS_W       = 5;    // group_size register width
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_GROUP_DEF = 16;
    localparam logic [GS_W-1:0] GROUP_SIZE_RST = 5'd4;
    localparam logic            TAIL_MODE_RST  = 1'b0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_MODE  = 8'd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic busy;       // draining a group
        logic pend;       // read data waiting for the output register
        logic left_zero;  // no reads left to issue
        logic fill_zero;  // store holds no elements
    } t_ctrl_status;

endpackage

// ===== hdl/kgr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgr_if
// Valid/ready channels: input elements, reordered results, register writes.
// ----------------------------------------------------------------------------
interface kgr_item_if;
    logic                            valid;
    logic                            ready;
    logic signed [kgr_pkg::VAL_W-1:0] item_value;
    logic                            end_of_list;

    modport source (output valid, output item_value, output end_of_list, input ready);
    modport sink   (input valid, input item_value, input end_of_list, output ready);
endinterface

interface kgr_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [kgr_pkg::VAL_W-1:0] out_value;
    logic                            out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

interface kgr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kgr_pkg::CFG_IDX_W-1:0]     index;
    logic [kgr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/kgr_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgr_store
// Group store: one write port, one read port, registered read data that
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
module kgr_store #(
    parameter int DEPTH = kgr_pkg::MAX_GROUP_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [kgr_pkg::VAL_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [kgr_pkg::VAL_W-1:0] o_rd_data
);

    logic [kgr_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [kgr_pkg::VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/kgr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgr_ctrl
// Sequencer: writes each element into the store, decides when a group is
// released, then reads it back in forward or reverse order into the output
// register, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module kgr_ctrl #(
    parameter int MAX_GROUP = kgr_pkg::MAX_GROUP_DEF,
    localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int CNT_W  = $clog2(MAX_GROUP + 1),
    localparam int KW     = (CNT_W > kgr_pkg::GS_W) ? CNT_W : kgr_pkg::GS_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [KW-1:0]             i_k,          // clamped group size
    input  logic                      i_tail_mode,
    kgr_item_if.sink                  i_item,
    kgr_result_if.source              o_result,
    output logic                      o_wr_en,
    output logic [ADDR_W-1:0]         o_wr_addr,
    output logic [kgr_pkg::VAL_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [ADDR_W-1:0]         o_rd_addr,
    input  logic [kgr_pkg::VAL_W-1:0] i_rd_data,
    output kgr_pkg::t_ctrl_status     o_status
);

    kgr_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]          r_fill, n_fill;
    logic [CNT_W-1:0]          r_left, n_left;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic                      r_rev, n_rev;
    logic                      r_lastf, n_lastf;
    logic                      r_pend, n_pend;
    logic                      r_pend_last, n_pend_last;
    logic                      r_out_valid, n_out_valid;
    logic [kgr_pkg::VAL_W-1:0] r_out_value, n_out_value;
    logic                      r_out_last, n_out_last;

    logic             accept;
    logic [CNT_W-1:0] count;
    logic             pass, full, load, issue;

    assign accept = i_item.valid && i_item.ready;
    assign count  = r_fill + CNT_W'(1);
    assign pass   = (i_k == '0);
    assign full   = (KW'(count) >= i_k);
    assign load   = r_pend && (!r_out_valid || o_result.ready);
    assign issue  = (r_state == kgr_pkg::ST_DRAIN) && (r_left != '0) && (!r_pend || load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kgr_pkg::ST_IDLE;
            r_fill      <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rev       <= n_rev;
        r_lastf     <= n_lastf;
        r_pend_last <= n_pend_last;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_left      = r_left;
        n_idx       = r_idx;
        n_rev       = r_rev;
        n_lastf     = r_lastf;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;

        // output register
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_out_value = i_rd_data;
            n_out_last  = r_pend_last;
            n_pend      = 1'b0;
        end

        case (r_state)
            kgr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (pass || full || i_item.end_of_list) begin
                        // release everything held plus this element
                        n_state = kgr_pkg::ST_DRAIN;
                        n_left  = count;
                        n_fill  = '0;
                        if (pass) begin
                            n_rev   = 1'b0;
                            n_lastf = i_item.end_of_list;
                        end else if (full) begin
                            n_rev   = 1'b1;
                            n_lastf = i_item.end_of_list;
                        end else begin
                            n_rev   = i_tail_mode;
                            n_lastf = 1'b1;
                        end
                        n_idx = n_rev ? r_fill[ADDR_W-1:0] : '0;
                    end else begin
                        n_fill = count;
                    end
                end
            end
            kgr_pkg::ST_DRAIN: begin
                if (issue) begin
                    o_rd_en     = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = r_lastf && (r_left == CNT_W'(1));
                    n_left      = r_left - CNT_W'(1);
                    n_idx       = r_rev ? (r_idx - ADDR_W'(1)) : (r_idx + ADDR_W'(1));
                end
                if ((r_left == '0) && !r_pend) begin
                    n_state = kgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kgr_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_item.ready = (r_state == kgr_pkg::ST_IDLE);

    assign o_wr_en   = accept;
    assign o_wr_addr = r_fill[ADDR_W-1:0];
    assign o_wr_data = i_item.item_value;

    assign o_result.valid     = r_out_valid;
    assign o_result.out_value = r_out_value;
    assign o_result.out_last  = r_out_last;

    assign o_status.busy      = (r_state == kgr_pkg::ST_DRAIN);
    assign o_status.pend      = r_pend;
    assign o_status.left_zero = (r_left == '0);
    assign o_status.fill_zero = (r_fill == '0);

endmodule

// ===== hdl/k_group_reverser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_group_reverser
// Reverses a stream of signed 32-bit list elements in groups of group_size.
// ----------------------------------------------------------------------------
// Elements enter on i_item, one word per accepted handshake; end_of_list marks
// the final element of a list. Each element is written to a MAX_GROUP-deep
// store on acceptance. When a group completes (the held count reaches
// group_size, clamped to MAX_GROUP), the held elements are read back in
// reverse order. At end_of_list a partial group is read back in arrival order
// (tail_mode 0) or reversed (tail_mode 1). With group_size 0 every element is
// passed through, after any elements still held, in arrival order. out_last
// marks the final word of each list. An element that only gets stored is
// taken without stopping the input; once an element releases n words, the
// input is held (ready low) until they are drained, as the store's single
// read port feeds the registered read data and then the output register one
// word per cycle while the output is not stalled, and the sequencer has
// returned to idle. Output stalls stretch the drain.
// The store needs no clearing after reset: only entries written in the open
// group are ever read. Write registers through i_cfg only while the block is
// idle: index 0 is group_size (5 bits), index 1 is tail_mode (1 bit).
// ----------------------------------------------------------------------------
module k_group_reverser #(
    parameter int MAX_GROUP = kgr_pkg::MAX_GROUP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kgr_item_if.sink      i_item,
    kgr_result_if.source  o_result,
    kgr_cfg_if.sink       i_cfg
);

    localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int KW     = (CNT_W > kgr_pkg::GS_W) ? CNT_W : kgr_pkg::GS_W;

    // configuration registers
    logic [kgr_pkg::GS_W-1:0] r_group_size;
    logic                     r_tail_mode;
    logic                     cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= kgr_pkg::GROUP_SIZE_RST;
            r_tail_mode  <= kgr_pkg::TAIL_MODE_RST;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                kgr_pkg::CFG_GROUP_SIZE: r_group_size <= i_cfg.data[kgr_pkg::GS_W-1:0];
                kgr_pkg::CFG_TAIL_MODE:  r_tail_mode  <= i_cfg.data[0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // oversized group acts as MAX_GROUP
    logic [KW-1:0] gs_ext, k_eff;
    assign gs_ext = KW'(r_group_size);
    assign k_eff  = (gs_ext > KW'(MAX_GROUP)) ? KW'(MAX_GROUP) : gs_ext;

    // store <-> sequencer
    logic                      wr_en, rd_en;
    logic [ADDR_W-1:0]         wr_addr, rd_addr;
    logic [kgr_pkg::VAL_W-1:0] wr_data, rd_data;
    kgr_pkg::t_ctrl_status     status;

    kgr_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_k         (k_eff),
        .i_tail_mode (r_tail_mode),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_status    (status)
    );

    // writes happen only in idle, reads only while draining: no overlap
    kgr_store #(
        .DEPTH (MAX_GROUP)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // end of list always empties the store and starts a drain
    a_eol_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.end_of_list) |=>
            (status.busy && status.fill_zero))
        else $error("end_of_list did not release the held group");

    // pending read data exists only during a drain
    a_pend_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.pend |-> status.busy)
        else $error("read data pending outside a drain");

    // drain ends once all reads are issued and delivered to the output reg
    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.busy && !status.pend && status.left_zero) |=> !status.busy)
        else $error("drain did not finish");
`endif

endmodule

// ===== verif/tb_k_group_reverser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_group_reverser
// Self-checking bench for the k-group reverser.
// ----------------------------------------------------------------------------
// Elements go in over a valid/ready channel, with random gaps. A model kept
// in this bench regroups them, and each word on the result channel is
// compared with the oldest word it predicts. The result side stalls at
// random. A short directed table covers the corners first: reset settings,
// value extremes, tails in both modes, pass-through, oversized and shrunk
// group sizes, held words flushed by pass-through, and an unused register
// index. Random lists follow, with register writes between lists and now and
// then in the middle of one.
// ----------------------------------------------------------------------------
module tb_k_group_reverser;

    localparam int          VAL_W       = kgr_pkg::VAL_W;
    localparam int          GS_W        = kgr_pkg::GS_W;
    localparam int          CFG_IDX_W   = kgr_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W  = kgr_pkg::CFG_DATA_W;
    localparam int          HALF_PERIOD = 6;       // 12 ns clock
    localparam int          RST_CYCLES  = 12;
    localparam int          MAX_GROUP   = kgr_pkg::MAX_GROUP_DEF;
    localparam int          RAND_ITEMS  = 180;
    localparam int          IDLE_CYCLES = 8;       // settle time before a register write
    localparam int          TAIL_CYCLES = 40;      // quiet time at the end
    localparam longint      TIMEOUT_NS  = 2_000_000;
    localparam logic [2:0]  NO_TYPED    = 3'd7;    // row is checked by the model only

    // a register index that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    // one reordered word as it should leave the block
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_word;

    // one line of the directed table
    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [CFG_DATA_W-1:0]     reg_data;
        logic signed [VAL_W-1:0]   value;
        logic                      eol;
        logic [2:0]                n_typed;   // NO_TYPED, or number of words typed in
        logic [3:0][VAL_W-1:0]     typed;     // typed[0] leaves first
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kgr_item_if   item_ch ();
    kgr_result_if result_ch ();
    kgr_cfg_if    cfg_ch ();

    k_group_reverser #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Regrouping model: its own copy of the store and the registers.
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0] held_vals [MAX_GROUP];
    int unsigned      held_cnt  = 0;
    logic [GS_W-1:0]  grp_size  = kgr_pkg::GROUP_SIZE_RST;
    logic             tail_rev  = kgr_pkg::TAIL_MODE_RST;

    t_word            step_words[$];     // words released by the latest element
    t_word            pending_words[$];  // words still owed by the block
    int               err_cnt   = 0;
    bit               calm      = 1'b0;  // no idling on either side while set
    t_dir_row         dir_tab[$];

    // empty the store, oldest first or newest first; last flag, if requested, on the final word
    function automatic void release_held(input logic rev, input logic last);
        int unsigned i;
        int unsigned idx;
        for (i = 0; i < held_cnt; i++) begin
            idx = rev ? (held_cnt - 1 - i) : i;
            step_words.push_back(t_word'{held_vals[idx], last && (i + 1 == held_cnt)});
        end
        held_cnt = 0;
    endfunction

    function automatic void reorder_step(input logic signed [VAL_W-1:0] v, input logic eol);
        int unsigned k;
        step_words.delete();
        // sizes past the store depth behave as the depth
        k = (grp_size > MAX_GROUP) ? MAX_GROUP : grp_size;
        if (k == 0) begin
            // pass-through: anything still held goes first, in order
            release_held(1'b0, 1'b0);
            step_words.push_back(t_word'{v, eol});
            return;
        end
        held_vals[held_cnt] = v;
        held_cnt++;
        // >= also covers a size lowered below the held count
        if (held_cnt >= k)
            release_held(1'b1, eol);
        else if (eol)
            release_held(tail_rev, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Table rows
    // ------------------------------------------------------------------------
    function automatic t_dir_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r          = '0;
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic signed [VAL_W-1:0] v, input logic eol);
        t_dir_row r;
        r         = '0;
        r.kind    = ROW_ITEM;
        r.value   = v;
        r.eol     = eol;
        r.n_typed = NO_TYPED;
        return r;
    endfunction

    function automatic t_dir_row item_typed(input logic signed [VAL_W-1:0] v, input logic eol,
                                            input logic [2:0] n, input logic [VAL_W-1:0] t0,
                                            input logic [VAL_W-1:0] t1,
                                            input logic [VAL_W-1:0] t2,
                                            input logic [VAL_W-1:0] t3);
        t_dir_row r;
        r         = item_row(v, eol);
        r.n_typed = n;
        r.typed   = {t3, t2, t1, t0};
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // ------------------------------------------------------------------------
    // Element driver. The model runs at the accepting edge; a typed row
    // queues its typed words instead, the model still keeps its state.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic signed [VAL_W-1:0] v, input logic eol,
                             input logic [2:0] n_typed, input logic [3:0][VAL_W-1:0] typed);
        int unsigned g;
        int unsigned i;
        item_ch.valid       <= 1'b1;
        item_ch.item_value  <= v;
        item_ch.end_of_list <= eol;
        do @(posedge i_clk); while (!item_ch.ready);
        reorder_step(v, eol);
        if (n_typed == NO_TYPED) begin
            foreach (step_words[j])
                pending_words.push_back(step_words[j]);
        end else begin
            for (i = 0; i < n_typed; i++)
                pending_words.push_back(t_word'{typed[i], eol && (i + 1 == n_typed)});
        end
        g = pick_gap();
        if (g != 0) begin
            item_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    // registers change only with nothing in flight; held words may stay
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        item_ch.valid <= 1'b0;
        wait_drained();
        repeat (IDLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == kgr_pkg::CFG_GROUP_SIZE)
            grp_size = data[GS_W-1:0];
        else if (idx == kgr_pkg::CFG_TAIL_MODE)
            tail_rev = data[0];
    endtask

    // random register write, upper data bits random too
    task automatic random_reg();
        logic [CFG_DATA_W-1:0] d;
        int unsigned           r;
        int unsigned           c;
        d = $urandom;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            write_reg(kgr_pkg::CFG_TAIL_MODE, d);
        end else if (r == 2) begin
            write_reg(CFG_UNUSED, d);
        end else begin
            c = $urandom_range(0, 9);
            case (c)
                0:       d[GS_W-1:0] = '0;
                1:       d[GS_W-1:0] = GS_W'(MAX_GROUP);
                2:       d[GS_W-1:0] = GS_W'($urandom_range(MAX_GROUP + 1, 31));
                default: d[GS_W-1:0] = GS_W'($urandom_range(1, 8));
            endcase
            write_reg(kgr_pkg::CFG_GROUP_SIZE, d);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, check against the oldest owed word.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        int unsigned g;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            result_ch.ready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge i_clk);
            g = pick_gap();
            if (g != 0) begin
                result_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got out_value %h out_last %b",
                         $time, result_ch.out_value, result_ch.out_last);
                err_cnt++;
            end else begin
                w = pending_words.pop_front();
                if (result_ch.out_value !== w.value) begin
                    $display("%0t: out_value mismatch, expected %h got %h",
                             $time, w.value, result_ch.out_value);
                    err_cnt++;
                end
                if (result_ch.out_last !== w.last) begin
                    $display("%0t: out_last mismatch, expected %b got %b",
                             $time, w.last, result_ch.out_last);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned sent_items;
        int unsigned len;
        int unsigned mid;
        int unsigned i;
        int unsigned r;
        logic signed [VAL_W-1:0] v;

        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.item_value  <= '0;
        item_ch.end_of_list <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: groups of four, tail kept in order
        dir_tab.push_back(item_typed(32'h7FFF_FFFF, 1'b0, 3'd0, '0, '0, '0, '0));
        dir_tab.push_back(item_typed(32'h8000_0000, 1'b0, 3'd0, '0, '0, '0, '0));
        dir_tab.push_back(item_typed(32'h0000_0000, 1'b0, 3'd0, '0, '0, '0, '0));
        dir_tab.push_back(item_typed(32'hFFFF_FFFF, 1'b0, 3'd4,
                                     32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
        dir_tab.push_back(item_typed(32'd1, 1'b1, 3'd1, 32'd1, '0, '0, '0));
        // reversed tail; only bit 0 of the data counts
        dir_tab.push_back(reg_row(kgr_pkg::CFG_TAIL_MODE, 32'hFFFF_FFFF));
        dir_tab.push_back(item_typed(32'd10, 1'b0, 3'd0, '0, '0, '0, '0));
        dir_tab.push_back(item_typed(32'd20, 1'b0, 3'd0, '0, '0, '0, '0));
        dir_tab.push_back(item_typed(32'd30, 1'b1, 3'd3, 32'd30, 32'd20, 32'd10, '0));
        // pass-through
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'h0000_0000));
        dir_tab.push_back(item_typed(32'd5, 1'b0, 3'd1, 32'd5, '0, '0, '0));
        dir_tab.push_back(item_typed(32'd6, 1'b1, 3'd1, 32'd6, '0, '0, '0));
        // size one acts as pass-through
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'h0000_0001));
        dir_tab.push_back(item_typed(32'h1234_5678, 1'b0, 3'd1, 32'h1234_5678, '0, '0, '0));
        dir_tab.push_back(item_typed(32'hDEAD_BEEF, 1'b1, 3'd1, 32'hDEAD_BEEF, '0, '0, '0));
        // oversized size holds, then a smaller size flushes all held words reversed
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'h0000_001F));
        dir_tab.push_back(item_row(32'd100, 1'b0));
        dir_tab.push_back(item_row(32'd101, 1'b0));
        dir_tab.push_back(item_row(32'd102, 1'b0));
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'hFFFF_FFE2));
        dir_tab.push_back(item_typed(32'd103, 1'b0, 3'd4, 32'd103, 32'd102, 32'd101, 32'd100));
        // held words, then pass-through: they leave in order before the new one
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'h0000_0005));
        dir_tab.push_back(item_row(32'd200, 1'b0));
        dir_tab.push_back(item_row(32'd201, 1'b0));
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'h0000_0000));
        dir_tab.push_back(item_typed(32'd202, 1'b1, 3'd3, 32'd200, 32'd201, 32'd202, '0));
        // in-order tail again, then a group closed exactly by end of list
        dir_tab.push_back(reg_row(kgr_pkg::CFG_GROUP_SIZE, 32'h0000_0003));
        dir_tab.push_back(reg_row(kgr_pkg::CFG_TAIL_MODE, 32'hFFFF_FFFE));
        dir_tab.push_back(item_row(32'd300, 1'b0));
        dir_tab.push_back(item_typed(32'd301, 1'b1, 3'd2, 32'd300, 32'd301, '0, '0));
        dir_tab.push_back(item_row(32'd400, 1'b0));
        dir_tab.push_back(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));   // must change nothing
        dir_tab.push_back(item_row(32'd401, 1'b0));
        dir_tab.push_back(item_typed(32'd402, 1'b1, 3'd3, 32'd402, 32'd401, 32'd400, '0));

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_REG)
                write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_data);
            else
                send_word(dir_tab[k].value, dir_tab[k].eol, dir_tab[k].n_typed, dir_tab[k].typed);
        end

        // random lists, mostly short; a register write between some lists and
        // now and then inside one, with words still held
        sent_items = 0;
        while (sent_items < RAND_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
                random_reg();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            mid = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
            for (i = 0; i < len; i++) begin
                if (mid != 0 && i == mid)
                    random_reg();
                r = $urandom_range(0, 9);
                case (r)
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
                    default: v = $urandom;
                endcase
                send_word(v, i == len - 1, NO_TYPED, '0);
                sent_items++;
            end
        end
        calm = 1'b0;

        item_ch.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
